>>> rtl/sliding_median_filter_top_defines.svh
// Assertion macros used by the checker module smf_checker.
`ifndef SLIDING_MEDIAN_FILTER_TOP_DEFINES_SVH
`define SLIDING_MEDIAN_FILTER_TOP_DEFINES_SVH

// Checked outside reset only.
`define SMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define SMF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/smf_pkg.sv
`default_nettype none
package smf_pkg;

  localparam int WINDOW   = 5;
  localparam int SAMPLE_W = 16;
  localparam int RANK_W   = $clog2(WINDOW);

  // ranks of the two middle elements; equal for an odd window
  localparam int KHI = WINDOW / 2;
  localparam int KLO = (WINDOW % 2 == 1) ? WINDOW / 2 : WINDOW / 2 - 1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  // queue entries plus the three back-end stages
  localparam int MAX_INFLIGHT = QDEPTH + 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [WINDOW-1:0]       win_t;
  typedef logic [WINDOW-1:0]          cmp_row_t;
  typedef cmp_row_t [WINDOW-1:0]      cmp_mat_t;

  typedef struct packed {
    logic valid;
    win_t win;
  } win_beat_t;

endpackage
`default_nettype wire

>>> rtl/smf_front.sv
`default_nettype none
module smf_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire smf_pkg::sample_t in_sample,
  output smf_pkg::win_beat_t   push,
  input  wire logic            push_ready
);
  import smf_pkg::*;

  win_t win_r, win_nxt;
  logic take;

  assign in_ready = push_ready;
  assign take     = in_valid && push_ready;

  // newest sample sits at entry 0
  assign win_nxt = {win_r[WINDOW-2:0], in_sample};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (take) begin
      win_r <= win_nxt;
    end
  end

  assign push.valid = take;
  assign push.win   = win_nxt;

endmodule
`default_nettype wire

>>> rtl/smf_queue.sv
`default_nettype none
module smf_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire smf_pkg::win_beat_t push,
  output logic                  push_ready,
  output smf_pkg::win_beat_t    head,
  input  wire logic             pop
);
  import smf_pkg::*;

  win_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.win   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.win;
    end
  end

endmodule
`default_nettype wire

>>> rtl/smf_back.sv
`default_nettype none
module smf_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire smf_pkg::win_beat_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output smf_pkg::sample_t      out_median
);
  import smf_pkg::*;

  localparam logic [RANK_W-1:0] KLO_R = RANK_W'(KLO);
  localparam logic [RANK_W-1:0] KHI_R = RANK_W'(KHI);

  // stage 1: pairwise order matrix
  logic     v1_r;
  win_t     win1_r;
  cmp_mat_t cmp1_r, cmp_nxt;
  // stage 2: the two middle values
  logic     v2_r;
  sample_t  lo2_r, hi2_r, lo_nxt, hi_nxt;
  // stage 3: output register
  logic     v3_r;
  sample_t  med3_r;
  logic signed [SAMPLE_W:0] sum;

  logic adv1, adv2, adv3;
  logic [RANK_W-1:0] rank [WINDOW];

  assign adv3 = !v3_r || out_ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign pop  = head.valid && adv1;

  // cmp[i][j]: element j sorts ahead of element i; ties broken by index
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      for (int j = 0; j < WINDOW; j++) begin
        if (j < i) begin
          cmp_nxt[i][j] = (head.win[j] <= head.win[i]);
        end else begin
          cmp_nxt[i][j] = (head.win[j] < head.win[i]);
        end
      end
    end
  end

  // ranks form a permutation, so exactly one element matches each
  always_comb begin
    lo_nxt = '0;
    hi_nxt = '0;
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = RANK_W'($countones(cmp1_r[i]));
      if (rank[i] == KLO_R) lo_nxt = lo_nxt | win1_r[i];
      if (rank[i] == KHI_R) hi_nxt = hi_nxt | win1_r[i];
    end
  end

  // floored mean; collapses to the middle value for an odd window
  assign sum = {lo2_r[SAMPLE_W-1], lo2_r} + {hi2_r[SAMPLE_W-1], hi2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= head.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      win1_r <= head.win;
      cmp1_r <= cmp_nxt;
    end
    if (adv2 && v1_r) begin
      lo2_r <= lo_nxt;
      hi2_r <= hi_nxt;
    end
    if (adv3 && v2_r) begin
      med3_r <= sum[SAMPLE_W:1];
    end
  end

  assign out_valid  = v3_r;
  assign out_median = med3_r;

endmodule
`default_nettype wire

>>> rtl/sliding_median_filter_top.sv
// Sliding-window median filter. Each accepted sample enters a window of the
// WINDOW newest samples (zeros after reset) and yields one beat carrying the
// window median; for an even window, the floored mean of the two middle
// values. Sustained rate is one sample per cycle while the output is not
// stalled; each result passes through the queue and the registered back-end
// stages. The rate is set by the pairwise compare matrix of the back end. A
// two-entry queue sits between the window register and the back end, so up to
// five samples can be in flight before in_ready drops.
`default_nettype none
module sliding_median_filter_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire smf_pkg::sample_t in_sample,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output smf_pkg::sample_t      out_median
);
  import smf_pkg::*;

  win_beat_t push, head;
  logic      push_ready, pop;

  smf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .push       (push),
    .push_ready (push_ready)
  );

  smf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  smf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_median (out_median)
  );

endmodule
`default_nettype wire

>>> rtl/smf_checker.sv
`default_nettype none
`include "sliding_median_filter_top_defines.svh"
module smf_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire smf_pkg::sample_t out_median
);
  import smf_pkg::*;

  localparam int CNT_W = $clog2(MAX_INFLIGHT + 1);

  logic [CNT_W-1:0] inflight_r;
  logic             in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_beat && !out_beat) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (out_beat && !in_beat) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  `SMF_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !out_valid, "result after reset")
  `SMF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_median), "hold")
  `SMF_ASSERT(a_no_spurious, out_valid |-> inflight_r != '0, "result without sample")
  `SMF_ASSERT(a_bounded, inflight_r <= CNT_W'(MAX_INFLIGHT), "too many beats in flight")

endmodule

bind sliding_median_filter_top smf_checker u_smf_checker (.*);
`default_nettype wire

>>> sim/sliding_median_filter_top_test.sv
`default_nettype none
module sliding_median_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import smf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  sample_t in_sample = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t out_median;

  sample_t hist [WINDOW];
  sample_t median_q [$];
  int      mismatches = 0;
  int      cycle_count = 0;
  bit      bursty = 1'b0;
  int      stall_left = 0;

  sliding_median_filter_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_median (out_median)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side backpressure: random stall bursts while bursty is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (bursty && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // sorted-window median; even windows take the floored mean of the middle pair
  function automatic sample_t window_median(input sample_t w [WINDOW]);
    sample_t s [WINDOW];
    sample_t t;
    int      lo_v;
    int      hi_v;
    s = w;
    for (int i = 1; i < WINDOW; i++) begin
      for (int j = i; j > 0 && s[j-1] > s[j]; j--) begin
        t      = s[j];
        s[j]   = s[j-1];
        s[j-1] = t;
      end
    end
    if (WINDOW % 2 == 1) return s[WINDOW/2];
    lo_v = s[WINDOW/2 - 1];
    hi_v = s[WINDOW/2];
    return sample_t'((lo_v + hi_v) >>> 1);
  endfunction

  // inputs and outputs are sampled at the falling edge, where nothing moves
  initial begin
    sample_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (median_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: median %0d", out_median);
        end else begin
          want = median_q.pop_front();
          if (out_median !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("median mismatch: expected %0d got %0d", want, out_median);
          end
        end
      end
    end
  end

  task automatic send_sample(input sample_t s);
    bit took;
    if (bursty && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    for (int i = WINDOW - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = s;
    median_q.push_back(window_median(hist));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 4))
      0: return sample_t'(int'($urandom_range(0, 8)) - 4);  // many ties
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2: return sample_t'(int'($urandom_range(0, 6)) - 3 + ($urandom_range(0, 1) ? 32767 : -32768));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // zeros from reset take part until the window is full
  task automatic test_startup();
    send_sample(16'sd1000);
    send_sample(-16'sd2000);
    send_sample(16'sd3000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
  endtask

  task automatic test_extremes();
    repeat (WINDOW) send_sample(16'sh7FFF);
    repeat (WINDOW) send_sample(16'sh8000);
    for (int i = 0; i < 4; i++) send_sample(i[0] ? 16'sh7FFF : 16'sh8000);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
  endtask

  task automatic test_random_bursty(input int n);
    bursty = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 50) bursty = ~bursty;  // spans with no idling too
      send_sample(pick_sample());
    end
    bursty = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    for (int i = 0; i < 20; i++) send_sample(pick_sample());
    wait_drained();
    for (int i = 0; i < 20; i++) send_sample(pick_sample());
  endtask

  task automatic test_back_to_back(input int n);
    bursty = 1'b0;
    for (int i = 0; i < n; i++) send_sample(pick_sample());
  endtask

  initial begin
    for (int i = 0; i < WINDOW; i++) hist[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_startup();
    test_extremes();
    test_random_bursty(460);
    test_pause_until_drained();
    test_back_to_back(200);
    wait_drained();
    if (mismatches == 0 && median_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
